### design/cmdsplit_pkg.sv
`default_nettype none

package cmdsplit_pkg;

    localparam int unsigned CHAR_W = 16;

    localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB    = 16'h0009;

    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_ARG_END  = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    // which part of the held plan goes out on an emit
    typedef enum logic [1:0] {
        SEL_RUN,
        SEL_ARGEND,
        SEL_CHAR,
        SEL_LINEEND
    } t_sel;

    typedef struct packed {
        logic accept;
        logic emit;
        t_sel sel;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_empty;  // for the beat being offered on the input
        logic run_left;
        logic run_one;
        logic argend;
        logic chr;
        logic lineend;
    } t_dp_status;

endpackage

`default_nettype wire

### design/command_line_word_splitter_core.sv
// Command line word splitter.
// Slave stream: one UTF-16 code unit a beat in s_axis_tdata; s_axis_tlast marks the end
// of the line, with tdata then ignored. Master stream: argument characters, argument-end
// marks and a line-end mark, kind in m_axis_tuser; m_axis_tlast flags the final result
// caused by an input beat. Run clamping is reported on the line-end beat.
// Blank and backslash runs are held until the next character decides them, so an input
// beat may cause no result or up to MAX_RUN + 2 results.
// Flow: the input beat is taken while idle and its plan is registered; its results then
// leave one per cycle while the receiver is ready, each through the output register.
// A beat that only extends a held run or toggles quotes yields no result and leaves
// the input ready. A single result sequencer emits the results; the next input is taken
// once the last result of the current one is in the output register.
// Reset (synchronous, active low) clears the line state; there is no clearing pass.
// When the receiver stalls, the output register holds its beat and emission pauses;
// the input stays blocked until the last result has been emitted into the output register.
`default_nettype none

module command_line_word_splitter_core
    import cmdsplit_pkg::*;
#(
    parameter int unsigned MAX_RUN = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] ch
    input  wire logic        s_axis_tlast,   // end_of_line
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] out_char, [16] run_clamped
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // last
);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [1:0]        out_kind;
    logic [CHAR_W-1:0] out_char;
    logic              out_clamped;
    logic              out_last;

    cmdsplit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cmdsplit_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_ch      (s_axis_tdata),
        .i_eol     (s_axis_tlast),
        .o_status  (status),
        .o_kind    (out_kind),
        .o_char    (out_char),
        .o_clamped (out_clamped),
        .o_last    (out_last)
    );

    assign m_axis_tdata = {7'b0, out_clamped, out_char};
    assign m_axis_tuser = out_kind;
    assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

### design/cmdsplit_ctrl.sv
`default_nettype none

module cmdsplit_ctrl
    import cmdsplit_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   any_left;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        out_free = !r_out_valid || i_out_ready;
        any_left = i_status.run_left || i_status.argend || i_status.chr || i_status.lineend;

        o_cmd        = '0;
        o_cmd.sel    = SEL_RUN;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        n_state      = r_state;

        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && !i_status.plan_empty) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!any_left) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.emit = 1'b1;
                    // order: held run, argument end, character, line end
                    if (i_status.run_left) begin
                        o_cmd.sel  = SEL_RUN;
                        o_cmd.last = i_status.run_one && !i_status.argend &&
                                     !i_status.chr && !i_status.lineend;
                    end else if (i_status.argend) begin
                        o_cmd.sel  = SEL_ARGEND;
                        o_cmd.last = !i_status.chr && !i_status.lineend;
                    end else if (i_status.chr) begin
                        o_cmd.sel  = SEL_CHAR;
                        o_cmd.last = !i_status.lineend;
                    end else begin
                        o_cmd.sel  = SEL_LINEEND;
                        o_cmd.last = 1'b1;
                    end
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_status.plan_empty) |=> !o_in_ready)
        else $error("input taken while a plan is still being emitted");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after last beat");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("emit overwrote an untaken output beat");
`endif

endmodule

`default_nettype wire

### design/cmdsplit_dp.sv
`default_nettype none

module cmdsplit_dp
    import cmdsplit_pkg::*;
#(
    parameter int unsigned MAX_RUN = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [CHAR_W-1:0] i_ch,
    input  wire logic              i_eol,
    output t_dp_status             o_status,
    output logic [1:0]             o_kind,
    output logic [CHAR_W-1:0]      o_char,
    output logic                   o_clamped,
    output logic                   o_last
);

    localparam int unsigned CW = $clog2(MAX_RUN + 1);

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_BLANK,
        PEND_BSLASH
    } t_pend;

    // line state
    logic               r_in_quotes,   n_in_quotes;
    logic               r_arg_started, n_arg_started;
    t_pend              r_pend,        n_pend;
    logic [CW-1:0]      r_run_cnt,     n_run_cnt;
    logic [MAX_RUN-1:0] r_blank_pat,   n_blank_pat;
    logic               r_clamp_seen,  n_clamp_seen;

    // plan for the accepted beat
    logic               r_p_blank,  p_blank;
    logic [CW-1:0]      r_p_cnt,    p_cnt;
    logic [MAX_RUN-1:0] r_p_pat,    p_pat;
    logic               r_p_argend, p_argend;
    logic               r_p_char,   p_char;
    logic [CHAR_W-1:0]  r_p_val,    p_val;
    logic               r_p_lineend, p_lineend;
    logic               r_p_clamp,  p_clamp;

    logic               is_blank;
    logic               is_bslash;
    logic               is_quote;
    logic               do_resolve;
    logic               do_grow;
    logic               grow_tab;
    logic [CW-1:0]      base_cnt;
    logic [MAX_RUN-1:0] base_pat;

    always_comb begin
        is_blank  = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
        is_bslash = (i_ch == CH_BSLASH);
        is_quote  = (i_ch == CH_QUOTE);

        n_in_quotes   = r_in_quotes;
        n_arg_started = r_arg_started;
        n_pend        = r_pend;
        n_run_cnt     = r_run_cnt;
        n_blank_pat   = r_blank_pat;
        n_clamp_seen  = r_clamp_seen;

        p_blank   = 1'b0;
        p_cnt     = '0;
        p_pat     = r_blank_pat;
        p_argend  = 1'b0;
        p_char    = 1'b0;
        p_val     = i_ch;
        p_lineend = 1'b0;
        p_clamp   = r_clamp_seen;

        do_resolve = 1'b0;
        do_grow    = 1'b0;
        grow_tab   = (i_ch == CH_TAB);
        base_cnt   = '0;
        base_pat   = '0;

        if (i_eol) begin
            // trailing blanks are dropped, held backslashes go out as they are
            if (r_pend == PEND_BSLASH) begin
                p_cnt = r_run_cnt;
            end
            p_argend      = r_arg_started;
            p_lineend     = 1'b1;
            n_in_quotes   = 1'b0;
            n_arg_started = 1'b0;
            n_pend        = PEND_NONE;
            n_run_cnt     = '0;
            n_blank_pat   = '0;
            n_clamp_seen  = 1'b0;
        end else if (is_blank) begin
            if (r_arg_started) begin
                if (r_pend != PEND_BLANK) begin
                    do_resolve = 1'b1;
                end else begin
                    base_cnt = r_run_cnt;
                    base_pat = r_blank_pat;
                end
                do_grow = 1'b1;
                n_pend  = PEND_BLANK;
            end
        end else if (is_bslash) begin
            if (r_pend != PEND_BSLASH) begin
                do_resolve = 1'b1;
            end else begin
                base_cnt = r_run_cnt;
            end
            do_grow       = 1'b1;
            grow_tab      = 1'b0;
            n_pend        = PEND_BSLASH;
            n_arg_started = 1'b1;
        end else if (is_quote) begin
            if (r_pend == PEND_BSLASH) begin
                // halve the run; an odd run makes the quote literal
                p_cnt = r_run_cnt >> 1;
                if (r_run_cnt[0]) begin
                    p_char = 1'b1;
                    p_val  = CH_QUOTE;
                end else begin
                    n_in_quotes = !r_in_quotes;
                end
            end else begin
                do_resolve  = 1'b1;
                n_in_quotes = !r_in_quotes;
            end
            n_pend        = PEND_NONE;
            n_run_cnt     = '0;
            n_blank_pat   = '0;
            n_arg_started = 1'b1;
        end else begin
            do_resolve    = 1'b1;
            p_char        = 1'b1;
            n_pend        = PEND_NONE;
            n_run_cnt     = '0;
            n_blank_pat   = '0;
            n_arg_started = 1'b1;
        end

        if (do_resolve) begin
            if (r_pend == PEND_BLANK) begin
                if (r_in_quotes) begin
                    p_blank = 1'b1;
                    p_cnt   = r_run_cnt;
                end else begin
                    p_argend = 1'b1;
                end
            end else if ((r_pend == PEND_BSLASH) && !is_quote) begin
                p_cnt = r_run_cnt;
            end
        end

        if (do_grow) begin
            if (base_cnt >= CW'(MAX_RUN)) begin
                n_clamp_seen = 1'b1;
                n_run_cnt    = base_cnt;
                n_blank_pat  = base_pat;
            end else begin
                n_run_cnt   = base_cnt + CW'(1);
                n_blank_pat = base_pat | ({{(MAX_RUN-1){1'b0}}, grow_tab} << base_cnt);
            end
        end

        o_status.plan_empty = (p_cnt == '0) && !p_argend && !p_char && !p_lineend;
        o_status.run_left   = (r_p_cnt != '0);
        o_status.run_one    = (r_p_cnt == CW'(1));
        o_status.argend     = r_p_argend;
        o_status.chr        = r_p_char;
        o_status.lineend    = r_p_lineend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes   <= 1'b0;
            r_arg_started <= 1'b0;
            r_pend        <= PEND_NONE;
            r_run_cnt     <= '0;
            r_blank_pat   <= '0;
            r_clamp_seen  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_in_quotes   <= n_in_quotes;
            r_arg_started <= n_arg_started;
            r_pend        <= n_pend;
            r_run_cnt     <= n_run_cnt;
            r_blank_pat   <= n_blank_pat;
            r_clamp_seen  <= n_clamp_seen;
        end
    end

    // plan and output beat: loaded before use, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_blank   <= p_blank;
            r_p_cnt     <= p_cnt;
            r_p_pat     <= p_pat;
            r_p_argend  <= p_argend;
            r_p_char    <= p_char;
            r_p_val     <= p_val;
            r_p_lineend <= p_lineend;
            r_p_clamp   <= p_clamp;
        end else if (i_cmd.emit) begin
            o_last    <= i_cmd.last;
            o_clamped <= 1'b0;
            case (i_cmd.sel)
                SEL_RUN: begin
                    o_kind  <= KIND_CHAR;
                    if (r_p_blank) begin
                        o_char <= r_p_pat[0] ? CH_TAB : CH_SPACE;
                    end else begin
                        o_char <= CH_BSLASH;
                    end
                    r_p_cnt <= r_p_cnt - CW'(1);
                    r_p_pat <= r_p_pat >> 1;
                end
                SEL_ARGEND: begin
                    o_kind     <= KIND_ARG_END;
                    o_char     <= '0;
                    r_p_argend <= 1'b0;
                end
                SEL_CHAR: begin
                    o_kind   <= KIND_CHAR;
                    o_char   <= r_p_val;
                    r_p_char <= 1'b0;
                end
                SEL_LINEEND: begin
                    o_kind      <= KIND_LINE_END;
                    o_char      <= '0;
                    o_clamped   <= r_p_clamp;
                    r_p_lineend <= 1'b0;
                end
                default: begin
                    o_kind <= KIND_LINE_END;
                    o_char <= '0;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= CW'(MAX_RUN))
        else $error("held run longer than the run buffer");

    a_idle_run_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == PEND_NONE) |-> ((r_run_cnt == '0) && (r_blank_pat == '0)))
        else $error("run count left over with nothing held");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_eol) |=> (!r_arg_started && !r_in_quotes && !r_clamp_seen))
        else $error("line state not cleared at line end");
`endif

endmodule

`default_nettype wire
